// ===== rtl/core/vabd_pkg.sv =====
// Shared types, constants and the seven-segment decode for the voltmeter display block.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package vabd_pkg;

	localparam int ADC_W      = 10;
	localparam int SEG_W      = 7;
	localparam int SEL_W      = 2;
	localparam int BCD_W      = 8;
	localparam int TENTHS_W   = 6;

	localparam int SAMPLES_PER_AVERAGE_DEF = 8;

	// Scaling to tenths: floor((avg*33 + 511) / 1023). With x = avg*33 + 511,
	// floor(x / 1023) equals ((x + 1) * 1025) >> 20 for every x below 2**20,
	// so one constant multiply and an add give the exact quotient.
	localparam int SCALE_NUM    = 33;
	localparam int SCALE_ROUND  = 511;
	localparam int SCALE_DEN    = 1023;
	localparam int TENTHS_SHIFT = 20;
	localparam int TENTHS_MUL   = SCALE_NUM * (SCALE_DEN + 2);
	localparam int TENTHS_ADD   = (SCALE_ROUND + 1) * (SCALE_DEN + 2);
	localparam int SCALED_W     = 26;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic KIND_DISPLAY = 1'b0;
	localparam logic KIND_MEASURE = 1'b1;

	localparam logic [SEL_W-1:0] DIGIT_SEL_NONE = 2'b00;
	localparam logic [SEL_W-1:0] DIGIT_SEL_LOW  = 2'b01;
	localparam logic [SEL_W-1:0] DIGIT_SEL_HIGH = 2'b10;

	typedef struct packed {
		logic             operation;
		logic [ADC_W-1:0] adc_sample;
	} item_t;

	typedef struct packed {
		logic             result_kind;
		logic [SEG_W-1:0] segments;
		logic [SEL_W-1:0] digit_select;
		logic [BCD_W-1:0] voltage_bcd;
	} result_t;

	// Work handed from the accumulator to the display stage.
	typedef struct packed {
		logic             valid;
		logic             is_tick;
		logic [ADC_W-1:0] avg;
	} stage_t;

	function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] digit);
		logic [SEG_W-1:0] pattern;
		unique case (digit)
			4'h0: pattern = 7'h3F;
			4'h1: pattern = 7'h06;
			4'h2: pattern = 7'h5B;
			4'h3: pattern = 7'h4F;
			4'h4: pattern = 7'h66;
			4'h5: pattern = 7'h6D;
			4'h6: pattern = 7'h7D;
			4'h7: pattern = 7'h07;
			4'h8: pattern = 7'h7F;
			4'h9: pattern = 7'h6F;
			4'hA: pattern = 7'h77;
			4'hB: pattern = 7'h7C;
			4'hC: pattern = 7'h39;
			4'hD: pattern = 7'h5E;
			4'hE: pattern = 7'h79;
			4'hF: pattern = 7'h71;
			default: pattern = '0;
		endcase
		return pattern;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vabd_stream_if.sv =====
// Valid/ready channel carrying one packed payload per item.
// Payload types come from vabd_pkg.
`default_nettype none

interface vabd_stream_if #(
	parameter type payload_t = vabd_pkg::item_t
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vabd_accum.sv =====
// Accumulator: sums each sample group, forms its average and passes ticks on.
// Depends on vabd_pkg.
`default_nettype none

module vabd_accum #(
	parameter int SAMPLES_PER_AVERAGE = vabd_pkg::SAMPLES_PER_AVERAGE_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      valid_s1,
	input  wire vabd_pkg::item_t           item_s1,
	output vabd_pkg::stage_t               stage_s2
);

	localparam int N         = SAMPLES_PER_AVERAGE;
	localparam int LOG_N     = $clog2(N);
	localparam int SUM_W     = vabd_pkg::ADC_W + LOG_N;
	localparam int CNT_W     = (N > 1) ? LOG_N : 1;
	// Average by reciprocal: the shift is wide enough that the rounding-up
	// error of the multiplier never reaches the next integer.
	localparam int AVG_SHIFT = SUM_W + LOG_N + 1;
	localparam int AVG_MUL   = ((1 << AVG_SHIFT) + N - 1) / N;
	localparam int MUL_W     = AVG_SHIFT + 1;
	localparam int PROD_W    = SUM_W + MUL_W;

	logic [SUM_W-1:0]          sum_q;
	logic [CNT_W-1:0]          count_q;
	logic [SUM_W-1:0]          sum_next;
	logic [PROD_W-1:0]         avg_prod;
	logic [vabd_pkg::ADC_W-1:0] avg;
	logic                      group_done;

	assign sum_next   = sum_q + SUM_W'(item_s1.adc_sample);
	assign avg_prod   = PROD_W'(sum_next) * PROD_W'(AVG_MUL);
	assign avg        = avg_prod[AVG_SHIFT +: vabd_pkg::ADC_W];
	assign group_done = (count_q == CNT_W'(N - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			stage_s2 <= '0;
		end else if (en) begin
			stage_s2.avg <= avg;
			if (valid_s1 && item_s1.operation == vabd_pkg::OP_TICK) begin
				stage_s2.valid   <= 1'b1;
				stage_s2.is_tick <= 1'b1;
			end else if (valid_s1 && group_done) begin
				stage_s2.valid   <= 1'b1;
				stage_s2.is_tick <= 1'b0;
				sum_q            <= '0;
				count_q          <= '0;
			end else begin
				stage_s2.valid   <= 1'b0;
				stage_s2.is_tick <= 1'b0;
				if (valid_s1) begin
					sum_q   <= sum_next;
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vabd_display.sv =====
// Display stage: scales averages to BCD tenths, holds the shown value and
// drives the multiplexed digits into the result register. Depends on vabd_pkg.
`default_nettype none

module vabd_display (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire vabd_pkg::stage_t stage_s2,
	output logic                  result_valid_q,
	output vabd_pkg::result_t     result_q
);

	logic [vabd_pkg::BCD_W-1:0]    shown_bcd_q;
	logic                          show_low_q;
	logic [vabd_pkg::SCALED_W-1:0] scaled;
	logic [vabd_pkg::TENTHS_W-1:0] tenths;
	logic [1:0]                    tens;
	logic [vabd_pkg::TENTHS_W-1:0] ones;
	logic [vabd_pkg::BCD_W-1:0]    bcd_new;
	logic [3:0]                    shown_digit;

	assign scaled = vabd_pkg::SCALED_W'(stage_s2.avg) * vabd_pkg::SCALED_W'(vabd_pkg::TENTHS_MUL)
		+ vabd_pkg::SCALED_W'(vabd_pkg::TENTHS_ADD);
	assign tenths = scaled[vabd_pkg::TENTHS_SHIFT +: vabd_pkg::TENTHS_W];

	// Tenths never exceed 33, so the tens digit is at most 3.
	always_comb begin
		priority if (tenths >= vabd_pkg::TENTHS_W'(30)) tens = 2'd3;
		else if (tenths >= vabd_pkg::TENTHS_W'(20))     tens = 2'd2;
		else if (tenths >= vabd_pkg::TENTHS_W'(10))     tens = 2'd1;
		else                                            tens = 2'd0;
	end

	assign ones        = tenths - vabd_pkg::TENTHS_W'(tens) * vabd_pkg::TENTHS_W'(10);
	assign bcd_new     = {2'b00, tens, ones[3:0]};
	assign shown_digit = show_low_q ? shown_bcd_q[3:0] : shown_bcd_q[7:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			shown_bcd_q    <= '0;
			show_low_q     <= 1'b0;
		end else if (en) begin
			result_valid_q <= stage_s2.valid;
			if (stage_s2.valid) begin
				if (stage_s2.is_tick) begin
					show_low_q <= ~show_low_q;
				end else begin
					shown_bcd_q <= bcd_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (stage_s2.is_tick) begin
				result_q.result_kind  <= vabd_pkg::KIND_DISPLAY;
				result_q.segments     <= vabd_pkg::seg_decode(shown_digit);
				result_q.digit_select <= show_low_q ? vabd_pkg::DIGIT_SEL_LOW
					: vabd_pkg::DIGIT_SEL_HIGH;
				result_q.voltage_bcd  <= shown_bcd_q;
			end else begin
				result_q.result_kind  <= vabd_pkg::KIND_MEASURE;
				result_q.segments     <= '0;
				result_q.digit_select <= vabd_pkg::DIGIT_SEL_NONE;
				result_q.voltage_bcd  <= bcd_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/voltmeter_average_bcd_display.sv =====
// Items pass the input and average registers on to the result register.
// Throughput: one item per cycle; the three registers (input, average, result)
// advance together, and hold while the result register is full and not taken.
// Reset clears the group sum and count, the shown value (zero) and the digit
// order (high digit first); no results are pending after reset.
`default_nettype none

module voltmeter_average_bcd_display #(
	parameter int SAMPLES_PER_AVERAGE = vabd_pkg::SAMPLES_PER_AVERAGE_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	vabd_stream_if.sink   item,
	vabd_stream_if.source result
);

	logic              advance;
	logic              valid_s1;
	vabd_pkg::item_t   item_s1;
	vabd_pkg::stage_t  stage_s2;
	logic              result_valid_q;
	vabd_pkg::result_t result_q;

	assign advance    = !result_valid_q || result.ready;
	assign item.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item.data;
		end
	end

	vabd_accum #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.stage_s2 (stage_s2)
	);

	vabd_display u_display (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.stage_s2       (stage_s2),
		.result_valid_q (result_valid_q),
		.result_q       (result_q)
	);

	assign result.valid = result_valid_q;
	assign result.data  = result_q;

endmodule

`default_nettype wire

// ===== dv/tb_voltmeter_average_bcd_display.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for voltmeter_average_bcd_display: sample averaging, BCD readout and
// digit multiplexing are predicted per accepted item and compared on every result.
// Depends on vabd_pkg and vabd_stream_if from the RTL.

module tb_voltmeter_average_bcd_display;

	localparam int GROUP_SIZE   = vabd_pkg::SAMPLES_PER_AVERAGE_DEF;
	localparam int LATENCY      = 3;
	localparam int LONG_HOLD    = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int RUN_LIMIT    = 100000;
	localparam int ADC_MAX      = (1 << vabd_pkg::ADC_W) - 1;

	// Segment patterns for hex digits, digit 0 in the lowest seven bits.
	localparam logic [16*vabd_pkg::SEG_W-1:0] GLYPHS = {
		7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
		7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vabd_stream_if #(.payload_t(vabd_pkg::item_t))   sample_ch ();
	vabd_stream_if #(.payload_t(vabd_pkg::result_t)) readout_ch ();

	voltmeter_average_bcd_display dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (sample_ch),
		.result (readout_ch)
	);

	always #1 clk = ~clk;

	// Predicted state of the voltmeter.
	int unsigned group_sum;
	int unsigned group_count;
	logic [vabd_pkg::BCD_W-1:0] held_bcd;
	bit low_digit_next;

	vabd_pkg::result_t due_readouts[$];
	int mismatches = 0;

	bit send_gaps = 1'b0;
	bit receive_stalls = 1'b0;
	bit hold_request = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int run_cycles = 0;

	task automatic report(input string field, input int got, input int want);
		$display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $realtime, field, got, want);
		mismatches++;
	endtask

	function automatic logic [vabd_pkg::SEG_W-1:0] glyph(input logic [3:0] digit);
		return GLYPHS[digit*vabd_pkg::SEG_W +: vabd_pkg::SEG_W];
	endfunction

	task automatic track_voltmeter(input vabd_pkg::item_t it);
		int unsigned mean;
		int unsigned tenths;
		vabd_pkg::result_t r;
		r = '0;
		if (it.operation == vabd_pkg::OP_SAMPLE) begin
			group_sum += it.adc_sample;
			group_count++;
			if (group_count < GROUP_SIZE)
				return;
			mean = group_sum / GROUP_SIZE;
			tenths = (mean * 33 + 511) / 1023;
			held_bcd = {4'(tenths / 10), 4'(tenths % 10)};
			group_sum = 0;
			group_count = 0;
			r.result_kind = vabd_pkg::KIND_MEASURE;
			r.segments = '0;
			r.digit_select = vabd_pkg::DIGIT_SEL_NONE;
		end else begin
			r.result_kind = vabd_pkg::KIND_DISPLAY;
			r.segments = low_digit_next ? glyph(held_bcd[3:0]) : glyph(held_bcd[7:4]);
			r.digit_select = low_digit_next ? vabd_pkg::DIGIT_SEL_LOW
				: vabd_pkg::DIGIT_SEL_HIGH;
			low_digit_next = !low_digit_next;
		end
		r.voltage_bcd = held_bcd;
		due_readouts.push_back(r);
	endtask

	task automatic send_item(input logic op, input logic [vabd_pkg::ADC_W-1:0] sample);
		vabd_pkg::item_t it;
		it.operation = op;
		it.adc_sample = sample;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= it;
		do @(posedge clk); while (!sample_ch.ready);
		track_voltmeter(it);
	endtask

	task automatic wait_for_readouts();
		sample_ch.valid <= 1'b0;
		while (due_readouts.size() != 0) @(posedge clk);
	endtask

	function automatic logic [vabd_pkg::ADC_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ADC_MAX[vabd_pkg::ADC_W-1:0];
			default: return vabd_pkg::ADC_W'($urandom_range(0, ADC_MAX));
		endcase
	endfunction

	task automatic send_random(input int count);
		repeat (count) begin
			if ($urandom_range(0, 9) < 7)
				send_item(vabd_pkg::OP_SAMPLE, pick_sample());
			else
				send_item(vabd_pkg::OP_TICK, vabd_pkg::ADC_W'($urandom_range(0, ADC_MAX)));
		end
	endtask

	// The display starts at zero with the high digit first.
	task automatic test_after_reset();
		repeat (3) send_item(vabd_pkg::OP_TICK, '0);
	endtask

	// Full-scale samples give 3.3 V; a tick in mid group must not disturb the sum.
	task automatic test_full_scale();
		repeat (4) send_item(vabd_pkg::OP_SAMPLE, ADC_MAX[vabd_pkg::ADC_W-1:0]);
		send_item(vabd_pkg::OP_TICK, ADC_MAX[vabd_pkg::ADC_W-1:0]);
		repeat (4) send_item(vabd_pkg::OP_SAMPLE, ADC_MAX[vabd_pkg::ADC_W-1:0]);
		repeat (2) send_item(vabd_pkg::OP_TICK, '0);
	endtask

	// A sum of 127 truncates to a mean of 15, just below the step to one tenth.
	task automatic test_rounding_edge();
		repeat (7) send_item(vabd_pkg::OP_SAMPLE, 10'd16);
		send_item(vabd_pkg::OP_SAMPLE, 10'd15);
		send_item(vabd_pkg::OP_TICK, '0);
	endtask

	task automatic test_random_traffic(input int count);
		send_gaps = 1'b1;
		receive_stalls = 1'b1;
		send_random(count);
	endtask

	// The output is held off while items keep coming, so the block fills and stalls.
	task automatic test_output_hold();
		send_gaps = 1'b0;
		hold_request = 1'b1;
		send_random(60);
		send_gaps = 1'b1;
		send_random(40);
	endtask

	task automatic test_drain_pause();
		send_random(30);
		wait_for_readouts();
		send_random(30);
	endtask

	task automatic test_steady_stream(input int count);
		send_gaps = 1'b0;
		receive_stalls = 1'b0;
		send_random(count);
	endtask

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		group_sum = 0;
		group_count = 0;
		held_bcd = '0;
		low_digit_next = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_full_scale();
		test_rounding_edge();
		test_random_traffic(500);
		test_output_hold();
		test_drain_pause();
		test_steady_stream(200);
		wait_for_readouts();
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("voltmeter_average_bcd_display: match");
		else
			$display("voltmeter_average_bcd_display: mismatch");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off when asked for.
	initial begin
		readout_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				readout_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD - 1;
				readout_ch.ready <= 1'b0;
			end else if (receive_stalls && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				readout_ch.ready <= 1'b0;
			end else begin
				readout_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		vabd_pkg::result_t want;
		if (arst_n && readout_ch.valid && readout_ch.ready) begin
			if (due_readouts.size() == 0) begin
				report("result with none outstanding", int'(readout_ch.data), 0);
			end else begin
				want = due_readouts.pop_front();
				if (readout_ch.data.result_kind !== want.result_kind)
					report("result_kind", readout_ch.data.result_kind, want.result_kind);
				if (readout_ch.data.segments !== want.segments)
					report("segments", readout_ch.data.segments, want.segments);
				if (readout_ch.data.digit_select !== want.digit_select)
					report("digit_select", readout_ch.data.digit_select, want.digit_select);
				if (readout_ch.data.voltage_bcd !== want.voltage_bcd)
					report("voltage_bcd", readout_ch.data.voltage_bcd, want.voltage_bcd);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			run_cycles++;
			if ((sample_ch.valid && sample_ch.ready) || (readout_ch.valid && readout_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT || run_cycles >= RUN_LIMIT) begin
				$display("ERROR: run stopped after %0d cycles, %0d without an item moving",
					run_cycles, quiet_cycles);
				$display("voltmeter_average_bcd_display: mismatch");
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
rtl/core/vabd_pkg.sv
rtl/core/vabd_stream_if.sv
rtl/core/vabd_accum.sv
rtl/core/vabd_display.sv
rtl/core/voltmeter_average_bcd_display.sv
dv/tb_voltmeter_average_bcd_display.sv
